// ===== rtl/priority_bitmap_ready_scheduler_defines.svh =====
// assertion macros for the ready-queue scheduler
`ifndef PRIORITY_BITMAP_READY_SCHEDULER_DEFINES_SVH
`define PRIORITY_BITMAP_READY_SCHEDULER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PBRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define PBRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbrs_pkg.sv =====
// shared types and codes for the ready-queue scheduler
package pbrs_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_SCHEDULE = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_NOT_READY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2
    } t_phase;

    localparam int unsigned ID_W  = 5;
    localparam int unsigned LVL_W = 5;
    localparam int unsigned MAP_W = 32;

endpackage

// ===== rtl/pbrs_ram.sv =====
// generic single-write, single-read ram with registered read
module pbrs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/priority_bitmap_ready_scheduler.sv =====
// ready-queue scheduler: per-level fifo lists of thread ids with a level bitmap
// the result strobe is registered from the write phase, which follows the read phase
// one request at a time: start is not taken while busy, until the write phase is done
// remove repeats the read phase, fetching the level ram entry of its stored level
// reset clears the bitmap, ready bits and running thread at once; no clearing pass
// the receiver cannot stall; each result strobe is shown for exactly one cycle
module priority_bitmap_ready_scheduler #(
    parameter int unsigned NUM_LEVELS  = 32,
    parameter int unsigned NUM_THREADS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_command,
    input  logic [pbrs_pkg::ID_W-1:0]  i_thread_id,
    input  logic [pbrs_pkg::LVL_W-1:0] i_priority_req,
    output logic                       o_strobe,
    output logic [1:0]                 o_status,
    output logic                       o_switch_needed,
    output logic [pbrs_pkg::ID_W-1:0]  o_next_thread,
    output logic [pbrs_pkg::ID_W-1:0]  o_prev_thread,
    output logic                       o_prev_valid,
    output logic [pbrs_pkg::LVL_W-1:0] o_next_priority,
    output logic [pbrs_pkg::MAP_W-1:0] o_ready_levels
);
    import pbrs_pkg::*;

    localparam int unsigned TW  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int unsigned LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int unsigned LKW = TW + 1;  // link holds nil flag on top

    // head/tail per level packed; stored level per thread
    localparam int unsigned LVW = 2 * TW;
    localparam int unsigned THW = LW;

    t_phase r_phase, n_phase;
    t_cmd   r_cmd;
    logic [ID_W-1:0]  r_tid;
    logic [LW-1:0]    r_lv;
    logic             r_tid_ok;
    logic [NUM_LEVELS-1:0]  r_bitmap, n_bitmap;
    logic [NUM_THREADS-1:0] r_ready, n_ready;
    logic [ID_W-1:0]  r_run_thread, n_run_thread;
    logic             r_run_valid, n_run_valid;
    logic [LW-1:0]    r_run_level, n_run_level;

    logic             r_strobe;
    logic [1:0]       r_status, n_status;
    logic             r_sw, n_sw;
    logic [ID_W-1:0]  r_next, n_next, r_prev, n_prev;
    logic             r_pvalid, n_pvalid;
    logic [LVL_W-1:0] r_npri, n_npri;

    // level memory holds head and tail, thread memory holds the stored level
    logic          lv_we;
    logic [LW-1:0] lv_waddr, lv_raddr;
    logic [LVW-1:0] lv_wdata, lv_rdata;
    logic          th_we;
    logic [TW-1:0] th_waddr, th_raddr;
    logic [THW-1:0] th_wdata, th_rdata;

    pbrs_ram #(.WIDTH(LVW), .DEPTH(NUM_LEVELS)) u_level_ram (
        .i_clk(i_clk), .i_we(lv_we), .i_waddr(lv_waddr), .i_wdata(lv_wdata),
        .i_raddr(lv_raddr), .o_rdata(lv_rdata)
    );

    pbrs_ram #(.WIDTH(THW), .DEPTH(NUM_THREADS)) u_thread_ram (
        .i_clk(i_clk), .i_we(th_we), .i_waddr(th_waddr), .i_wdata(th_wdata),
        .i_raddr(th_raddr), .o_rdata(th_rdata)
    );

    // link memories need up to three writes per insert; kept in registers per field
    logic [LKW-1:0] r_next_lk [NUM_THREADS];
    logic [LKW-1:0] r_prev_lk [NUM_THREADS];

    // lowest set level of the bitmap
    logic [LW-1:0] low_lv;
    always_comb begin
        low_lv = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_bitmap[i]) begin
                low_lv = LW'(i);
            end
        end
    end

    logic [LW-1:0] sat_pri;
    logic [TW-1:0] tid_t;
    logic          in_ok;
    assign tid_t  = TW'(i_thread_id);
    assign in_ok  = ({27'd0, i_thread_id} < NUM_THREADS);
    assign sat_pri = ({27'd0, i_priority_req} >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                              : LW'(i_priority_req);

    logic [TW-1:0] r_tid_t;
    assign r_tid_t = TW'(r_tid);

    // fields read back in the write phase
    logic [TW-1:0]  rd_head, rd_tail;
    logic [LW-1:0]  rd_lvl;
    logic [LKW-1:0] pv, nx;
    logic           pv_nil, nx_nil;
    assign rd_head = lv_rdata[LVW-1:TW];
    assign rd_tail = lv_rdata[TW-1:0];
    assign rd_lvl  = th_rdata;
    assign pv      = r_prev_lk[r_tid_t];
    assign nx      = r_next_lk[r_tid_t];
    assign pv_nil  = pv[LKW-1];
    assign nx_nil  = nx[LKW-1];

    logic issue;
    assign issue = start && !busy;
    assign busy  = (r_phase != PH_IDLE);

    // read addresses: request level for insert, lowest level for schedule, stored level for remove
    logic          r_lv_pending;
    assign lv_raddr = (r_phase == PH_READ && r_cmd == CMD_REMOVE) ? rd_lvl
                    : (issue ? ((t_cmd'(i_command) == CMD_SCHEDULE) ? low_lv : sat_pri)
                             : r_lv);
    assign th_raddr = issue ? tid_t : r_tid_t;

    // phase sequencing and write-back
    always_comb begin
        n_phase = r_phase;
        n_bitmap = r_bitmap; n_ready = r_ready;
        n_run_thread = r_run_thread; n_run_valid = r_run_valid; n_run_level = r_run_level;
        n_status = ST_OK; n_sw = 1'b0; n_next = '0; n_prev = '0; n_pvalid = 1'b0;
        n_npri = '0;
        lv_we = 1'b0; lv_waddr = r_lv; lv_wdata = lv_rdata;
        th_we = 1'b0; th_waddr = r_tid_t; th_wdata = th_rdata;
        unique case (r_phase)
            PH_IDLE: begin
                if (issue) begin
                    n_phase = PH_READ;
                end
            end
            PH_READ: begin
                n_phase = PH_WRITE;
            end
            PH_WRITE: begin
                n_phase = PH_IDLE;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        if (!r_tid_ok) begin
                            n_status = ST_NOT_READY;
                        end else if (r_ready[r_tid_t]) begin
                            n_status = ST_DUPLICATE;
                        end else begin
                            lv_we = 1'b1;
                            lv_wdata = r_bitmap[r_lv] ? {rd_head, r_tid_t} : {r_tid_t, r_tid_t};
                            th_we = 1'b1;
                            th_wdata = r_lv;
                            n_bitmap[r_lv] = 1'b1;
                            n_ready[r_tid_t] = 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!r_tid_ok || !r_ready[r_tid_t]) begin
                            n_status = ST_NOT_READY;
                        end else begin
                            lv_we = 1'b1;
                            lv_waddr = r_lv;
                            lv_wdata = {pv_nil ? (nx_nil ? {TW{1'b0}} : nx[TW-1:0]) : rd_head,
                                        nx_nil ? (pv_nil ? {TW{1'b0}} : pv[TW-1:0]) : rd_tail};
                            if (pv_nil && nx_nil) begin
                                n_bitmap[r_lv] = 1'b0;
                            end
                            n_ready[r_tid_t] = 1'b0;
                        end
                    end
                    CMD_SCHEDULE: begin
                        n_prev = r_run_thread;
                        n_pvalid = r_run_valid;
                        if (r_bitmap == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_next = ID_W'(rd_head);
                            n_npri = LVL_W'(r_lv);
                            if (!r_run_valid || ID_W'(rd_head) != r_run_thread) begin
                                n_sw = 1'b1;
                                n_run_thread = ID_W'(rd_head);
                                n_run_valid = 1'b1;
                                n_run_level = r_lv;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // request capture; remove takes its level from the thread memory read
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cmd    <= t_cmd'(i_command);
            r_tid    <= i_thread_id;
            r_tid_ok <= in_ok;
            r_lv     <= (t_cmd'(i_command) == CMD_SCHEDULE) ? low_lv : sat_pri;
        end else if (r_phase == PH_READ && r_cmd == CMD_REMOVE) begin
            r_lv <= rd_lvl;
        end
    end

    // the remove reads the level ram after the thread ram read, so hold an extra flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv_pending <= 1'b0;
        end else begin
            r_lv_pending <= (r_phase == PH_READ && r_cmd == CMD_REMOVE);
        end
    end

    // link registers updated in the write phase
    always_ff @(posedge i_clk) begin
        if (r_phase == PH_WRITE && r_tid_ok) begin
            if (r_cmd == CMD_INSERT && !r_ready[r_tid_t]) begin
                r_next_lk[r_tid_t] <= {1'b1, {TW{1'b0}}};
                r_prev_lk[r_tid_t] <= r_bitmap[r_lv] ? {1'b0, rd_tail} : {1'b1, {TW{1'b0}}};
                if (r_bitmap[r_lv]) begin
                    r_next_lk[rd_tail] <= {1'b0, r_tid_t};
                end
            end else if (r_cmd == CMD_REMOVE && r_ready[r_tid_t]) begin
                if (!pv_nil) begin
                    r_next_lk[pv[TW-1:0]] <= nx;
                end
                if (!nx_nil) begin
                    r_prev_lk[nx[TW-1:0]] <= pv;
                end
            end
        end
    end

    // control state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bitmap <= '0;
            r_ready <= '0;
            r_run_thread <= '0;
            r_run_valid <= 1'b0;
            r_run_level <= LW'(NUM_LEVELS - 1);
            r_strobe <= 1'b0;
        end else begin
            r_phase <= (r_phase == PH_READ && r_cmd == CMD_REMOVE && !r_lv_pending)
                     ? PH_READ : n_phase;
            r_bitmap <= n_bitmap;
            r_ready <= n_ready;
            r_run_thread <= n_run_thread;
            r_run_valid <= n_run_valid;
            r_run_level <= n_run_level;
            r_strobe <= (r_phase == PH_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_WRITE) begin
            r_status <= n_status; r_sw <= n_sw; r_next <= n_next;
            r_prev <= n_prev; r_pvalid <= n_pvalid; r_npri <= n_npri;
        end
    end

    logic [MAP_W-1:0] map_out;
    always_comb begin
        map_out = '0;
        map_out[NUM_LEVELS-1:0] = r_bitmap;
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_switch_needed = r_sw;
    assign o_next_thread   = r_next;
    assign o_prev_thread   = r_prev;
    assign o_prev_valid    = r_pvalid;
    assign o_next_priority = r_npri;
    assign o_ready_levels  = map_out;
endmodule

// ===== rtl/pbrs_checker.sv =====
// port-level checks for the ready-queue scheduler, bound to the top level
`include "priority_bitmap_ready_scheduler_defines.svh"
module pbrs_port_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_strobe,
    input logic [1:0]                 o_status,
    input logic                       o_switch_needed,
    input logic [pbrs_pkg::MAP_W-1:0] o_ready_levels
);
    import pbrs_pkg::*;

    // a request makes the block busy in the next cycle
    `PBRS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, start && !busy, busy,
        "no busy after request")
    // a strobe ends the busy period
    `PBRS_ASSERT_IMPL(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "strobe while busy")
    // a switch only on a successful schedule with a ready level
    `PBRS_ASSERT_IMPL(a_switch_ok, i_clk, i_rst_n, o_strobe && o_switch_needed,
        o_status == ST_OK && o_ready_levels != '0, "switch without ready thread")
endmodule

bind priority_bitmap_ready_scheduler pbrs_port_checker u_pbrs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_status(o_status), .o_switch_needed(o_switch_needed),
    .o_ready_levels(o_ready_levels)
);
